FILE: rtl/one_shot_timer_table_defines.svh
// assertion macros used by the top-level rtl file
`ifndef ONE_SHOT_TIMER_TABLE_DEFINES_SVH
`define ONE_SHOT_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define OSTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ostt assertion failed");

// next-cycle implication
`define OSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ostt assertion failed");

`endif

FILE: rtl/ostt_pkg.sv
package ostt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] op_t;
    localparam op_t OP_CREATE = 2'd0;
    localparam op_t OP_CANCEL = 2'd1;
    localparam op_t OP_TICK   = 2'd2;
    localparam op_t OP_NONE   = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t STAT_FIRED     = 3'd0;
    localparam status_t STAT_CREATED   = 3'd1;
    localparam status_t STAT_FULL      = 3'd2;
    localparam status_t STAT_CANCELLED = 3'd3;
    localparam status_t STAT_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] cookie;
        logic [31:0] deadline;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

FILE: rtl/ostt_cell.sv
module ostt_cell (
    input  logic               clk,
    input  ostt_pkg::cell_ctl_t ctl,
    input  ostt_pkg::entry_t   nbr,
    input  ostt_pkg::entry_t   bcast,
    output ostt_pkg::entry_t   q
);
    import ostt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // load wins over the shift from the younger neighbor
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.load)
        begin
            entry_next = bcast;
        end
        else if (ctl.shift)
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

FILE: rtl/one_shot_timer_table.sv
// channel   direction  bus fields (lowest bit up)
// s_*       in         tuser: op / tdata: now_ms, delay_ms, timer_handle, user_cookie
// m_*       out        tuser: status / tdata: out_handle, out_cookie / tlast: last
// cfg_*     in         cfg_wdata: firing_enabled, written when cfg_we is high
//
// a create fills the first free cell in its accept cycle and answers once the output is free
// a cancel or tick, once accepted, examines each stored timer as the chain rotates through the
// head cell, then closes the pass and issues any closing result; a disabled tick goes back to idle;
// closing words wait on m_tready, and a tick pass stalls while a fired word waits on
// m_tready and another one is found
// rst_n clears the fill count, the sequencer and the output valid; cell contents are not reset
module one_shot_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [127:0] s_tdata,  // now_ms, delay_ms, timer_handle, user_cookie
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // status
    output logic [63:0] m_tdata,   // out_handle, out_cookie
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_wdata  // firing_enabled
);
    import ostt_pkg::*;

    `include "one_shot_timer_table_defines.svh"

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // waiting for a word
        ST_PASS = 3'b010,   // walking the chain, one head entry per cycle unless a tick stalls
        ST_FIN  = 3'b100    // issuing the closing result
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;   // entries stored, oldest in cell 0
    logic [CNT_W-1:0]    len_reg, len_next;       // live length during a pass
    logic [CNT_W-1:0]    step_reg, step_next;     // head entries still to examine
    op_t                 op_reg, op_next;
    logic [31:0]         key_reg, key_next;       // handle for cancel, time for tick
    logic                found_reg, found_next;   // cancel matched / create had room
    logic [RES_W-1:0]    fired_reg, fired_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [31:0]         pend_handle_reg, pend_handle_next;
    logic [31:0]         pend_cookie_reg, pend_cookie_next;
    logic                firing_en_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             out_status_reg;
    logic [31:0]         out_handle_reg, out_cookie_reg;
    logic                out_last_reg;

    // input word fields
    op_t         in_op;
    logic [31:0] in_now, in_timeout, in_handle, in_cookie;
    assign in_op      = s_tuser;
    assign in_now     = s_tdata[31:0];
    assign in_timeout = s_tdata[63:32];
    assign in_handle  = s_tdata[95:64];
    assign in_cookie  = s_tdata[127:96];

    // cell chain
    entry_t    cell_q [TIMER_SLOTS];
    cell_ctl_t cell_ctl [TIMER_SLOTS];
    entry_t    bcast;
    entry_t    head;

    logic accept, out_free, in_pass, stepping, is_cancel, hit, stall, adv, create_ld;

    // result push into the output register
    logic        push;
    status_t     push_status;
    logic [31:0] push_handle, push_cookie;
    logic        push_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign head      = cell_q[0];
    assign in_pass   = (state_reg == ST_PASS);
    assign stepping  = in_pass && (step_reg != '0);
    assign is_cancel = (op_reg == OP_CANCEL);

    // decision on the head entry: first handle match, or expired under the result cap
    assign hit = is_cancel ? (!found_reg && (head.handle == key_reg))
                           : ((key_reg >= head.deadline) && (fired_reg < RES_W'(MAX_RESULTS)));

    // a second expiry cannot be held while the previous one still waits for the output
    assign stall     = stepping && !is_cancel && hit && pend_valid_reg && !out_free;
    assign adv       = stepping && !stall;
    assign create_ld = accept && (in_op == OP_CREATE) && (count_reg != CNT_W'(TIMER_SLOTS));

    // kept head entries go back in at the tail, created entries go in at the fill point
    always_comb
    begin
        if (in_pass)
        begin
            bcast = head;
        end
        else
        begin
            bcast.handle   = in_handle;
            bcast.cookie   = in_cookie;
            bcast.deadline = in_now + in_timeout;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            cell_ctl[i].shift = adv && (CNT_W'(i + 1) < len_reg);
            cell_ctl[i].load  = create_ld ? (CNT_W'(i) == count_reg)
                                          : (adv && !hit && (CNT_W'(i + 1) == len_reg));
        end
    end

    for (genvar g = 0; g < TIMER_SLOTS; g++)
    begin : g_cell
        entry_t nbr;
        if (g == TIMER_SLOTS - 1)
        begin : g_tail
            assign nbr = bcast;   // the tail cell never shifts
        end
        else
        begin : g_mid
            assign nbr = cell_q[g + 1];
        end

        ostt_cell u_cell (
            .clk   (clk),
            .ctl   (cell_ctl[g]),
            .nbr   (nbr),
            .bcast (bcast),
            .q     (cell_q[g])
        );
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        step_next        = step_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        found_next       = found_reg;
        fired_next       = fired_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_cookie_next = pend_cookie_reg;
        push             = 1'b0;
        push_status      = STAT_FIRED;
        push_handle      = key_reg;
        push_cookie      = '0;
        push_last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    key_next   = (in_op == OP_TICK) ? in_now : in_handle;
                    found_next = 1'b0;
                    fired_next = '0;
                    len_next   = count_reg;
                    step_next  = count_reg;
                    unique case (in_op)
                        OP_CREATE:
                        begin
                            found_next = create_ld;
                            if (create_ld)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            state_next = ST_FIN;
                        end
                        OP_CANCEL:
                        begin
                            state_next = ST_PASS;
                        end
                        OP_TICK:
                        begin
                            state_next = firing_en_reg ? ST_PASS : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;   // unused op, no effect
                        end
                    endcase
                end
            end
            ST_PASS:
            begin
                if (step_reg == '0)
                begin
                    count_next = len_reg;
                    state_next = ST_FIN;
                end
                else if (adv)
                begin
                    step_next = step_reg - 1'b1;
                    if (hit)
                    begin
                        len_next = len_reg - 1'b1;
                        if (is_cancel)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            // hold this expiry until we know whether another follows
                            if (pend_valid_reg)
                            begin
                                push        = 1'b1;
                                push_status = STAT_FIRED;
                                push_handle = pend_handle_reg;
                                push_cookie = pend_cookie_reg;
                                push_last   = 1'b0;
                            end
                            pend_valid_next  = 1'b1;
                            pend_handle_next = head.handle;
                            pend_cookie_next = head.cookie;
                            fired_next       = fired_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                unique case (op_reg)
                    OP_CREATE, OP_CANCEL:
                    begin
                        if (out_free)
                        begin
                            push = 1'b1;
                            if (op_reg == OP_CREATE)
                            begin
                                push_status = found_reg ? STAT_CREATED : STAT_FULL;
                            end
                            else
                            begin
                                push_status = found_reg ? STAT_CANCELLED : STAT_NOT_FOUND;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    OP_TICK:
                    begin
                        if (!pend_valid_reg)
                        begin
                            state_next = ST_IDLE;   // nothing expired
                        end
                        else if (out_free)
                        begin
                            push            = 1'b1;
                            push_status     = STAT_FIRED;
                            push_handle     = pend_handle_reg;
                            push_cookie     = pend_cookie_reg;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = push ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            len_reg        <= '0;
            step_reg       <= '0;
            op_reg         <= OP_NONE;
            found_reg      <= 1'b0;
            fired_reg      <= '0;
            pend_valid_reg <= 1'b0;
            firing_en_reg  <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            step_reg       <= step_next;
            op_reg         <= op_next;
            found_reg      <= found_next;
            fired_reg      <= fired_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we)
            begin
                firing_en_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        pend_handle_reg <= pend_handle_next;
        pend_cookie_reg <= pend_cookie_next;
        if (push)
        begin
            out_status_reg <= push_status;
            out_handle_reg <= push_handle;
            out_cookie_reg <= push_cookie;
            out_last_reg   <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_cookie_reg, out_handle_reg};
    assign m_tlast  = out_last_reg;

    // a pass only shrinks the table and never examines more entries than remain
    `OSTT_ASSERT_IMPL(a_pass_bounds, clk, rst_n, state_reg == ST_PASS,
        (len_reg <= count_reg) && (step_reg <= len_reg))
    // a held expiry exists only inside a tick
    `OSTT_ASSERT_IMPL(a_pend_in_tick, clk, rst_n, pend_valid_reg,
        (op_reg == OP_TICK) && (state_reg != ST_IDLE))
    // a create with room grows the table by exactly one
    `OSTT_ASSERT_NEXT(a_create_grows, clk, rst_n, create_ld,
        count_reg == $past(count_reg) + 1'b1)

endmodule
